### rtl/core/hstd_pkg.sv
// ----------------------------------------------------------------------------
// hstd_pkg
// Types and constants shared by the sponge damping block.
// ----------------------------------------------------------------------------
package hstd_pkg;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_CELL = 1'b1;

  localparam logic [2:0] REG_DOMAIN_BOTTOM    = 3'd0;
  localparam logic [2:0] REG_CELL_HEIGHT      = 3'd1;
  localparam logic [2:0] REG_RAMP_BASE        = 3'd2;
  localparam logic [2:0] REG_INV_SPONGE_DEPTH = 3'd3;
  localparam logic [2:0] REG_TABLE_COUNT      = 3'd4;

  // ramp value for 1.0 in Q1.16
  localparam logic [16:0] RAMP_ONE = 17'h10000;

  typedef struct packed {
    logic signed [31:0] domain_bottom;
    logic        [30:0] cell_height;
    logic signed [31:0] ramp_base;
    logic        [30:0] inv_sponge_depth;
    logic        [6:0]  table_count;
  } hstd_cfg_t;

  // word passed from front to back
  typedef struct packed {
    logic               op;
    logic        [5:0]  entry_index;
    logic signed [31:0] entry_height;
    logic signed [31:0] entry_temperature;
    logic signed [48:0] z;
    logic        [16:0] ramp;
    logic signed [31:0] temp;
    logic signed [31:0] src;
  } hstd_work_t;

endpackage

### rtl/core/hstd_ram.sv
// ----------------------------------------------------------------------------
// hstd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hstd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/hstd_fifo.sv
// ----------------------------------------------------------------------------
// hstd_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module hstd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] buf_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### rtl/core/hstd_front.sv
// ----------------------------------------------------------------------------
// hstd_front
// Takes input words, forms cell height and sponge ramp for cell words.
// ----------------------------------------------------------------------------
module hstd_front import hstd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_op,
  input  logic        [5:0]  in_entry_index,
  input  logic signed [31:0] in_entry_height,
  input  logic signed [31:0] in_entry_temperature,
  input  logic        [15:0] in_cell_level,
  input  logic signed [31:0] in_cell_temperature,
  input  logic signed [31:0] in_source_in,
  input  hstd_cfg_t          cfg,
  output logic               q_push,
  output hstd_work_t         q_data,
  input  logic               q_full
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MULZ = 5'b00010,
    F_ZSUM = 5'b00100,
    F_MULR = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t            st_r, st_nxt;
  logic               op_r;
  logic        [5:0]  idx_r;
  logic signed [31:0] eh_r, et_r, temp_r, src_r;
  logic        [15:0] lvl_r;
  logic        [46:0] kh_r;
  logic signed [48:0] z_r;
  logic        [62:0] prod_r;
  logic               neg_r, big_r;
  logic signed [49:0] d;
  logic        [46:0] rq;
  logic        [16:0] ramp;

  assign in_full = (st_r != F_IDLE);
  assign q_push  = (st_r == F_PUSH);
  assign d       = 50'(z_r) - 50'(cfg.ramp_base);
  assign rq      = prod_r[62:16];

  always_comb begin
    if (neg_r) begin
      ramp = '0;
    end else if (big_r) begin
      ramp = (cfg.inv_sponge_depth != '0) ? RAMP_ONE : '0;
    end else if (rq > 47'(RAMP_ONE)) begin
      ramp = RAMP_ONE;
    end else begin
      ramp = rq[16:0];
    end
  end

  always_comb begin
    q_data.op                = op_r;
    q_data.entry_index       = idx_r;
    q_data.entry_height      = eh_r;
    q_data.entry_temperature = et_r;
    q_data.z                 = z_r;
    q_data.ramp              = ramp;
    q_data.temp              = temp_r;
    q_data.src               = src_r;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: begin
        if (in_push) begin
          st_nxt = (in_op == OP_CELL) ? F_MULZ : F_PUSH;
        end
      end
      F_MULZ: st_nxt = F_ZSUM;
      F_ZSUM: st_nxt = F_MULR;
      F_MULR: st_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_push) begin
      op_r   <= in_op;
      idx_r  <= in_entry_index;
      eh_r   <= in_entry_height;
      et_r   <= in_entry_temperature;
      lvl_r  <= in_cell_level;
      temp_r <= in_cell_temperature;
      src_r  <= in_source_in;
      // load words carry no ramp
      neg_r  <= 1'b1;
      big_r  <= 1'b0;
    end
    if (st_r == F_MULZ) begin
      kh_r <= 47'(lvl_r) * 47'(cfg.cell_height);
    end
    if (st_r == F_ZSUM) begin
      z_r <= 49'(cfg.domain_bottom) + 49'(kh_r) + 49'(cfg.cell_height[30:1]);
    end
    if (st_r == F_MULR) begin
      neg_r  <= d[49] || (d == '0);
      big_r  <= !d[49] && (|d[49:32]);
      prod_r <= 63'(d[31:0]) * 63'(cfg.inv_sponge_depth);
    end
  end

endmodule

### rtl/core/hstd_back.sv
// ----------------------------------------------------------------------------
// hstd_back
// Profile table, bisection search, interpolation and damping arithmetic.
// ----------------------------------------------------------------------------
module hstd_back import hstd_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  hstd_work_t         q_data,
  input  logic        [6:0]  table_count,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_source_out
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [11:0] {
    B_IDLE   = 12'b000000000001,
    B_CHK0   = 12'b000000000010,
    B_CHKN   = 12'b000000000100,
    B_PROBE  = 12'b000000001000,
    B_DSET   = 12'b000000010000,
    B_DIV    = 12'b000000100000,
    B_INTERP = 12'b000001000000,
    B_REF    = 12'b000010000000,
    B_MUL1   = 12'b000100000000,
    B_MUL2   = 12'b001000000000,
    B_FIN    = 12'b010000000000,
    B_DONE   = 12'b100000000000
  } bstate_t;

  bstate_t            st_r;
  hstd_work_t         w_r;
  logic [AW-1:0]      lo_r, hi_r, mid_r;
  logic signed [31:0] hlo_r, tlo_r, hhi_r, thi_r, ref_r;
  logic [34:0]        rem_r;
  logic [33:0]        span_r;
  logic [15:0]        q_r;
  logic [3:0]         cnt_r;
  logic signed [49:0] ip_r;
  logic signed [34:0] t1_r;
  logic [31:0]        t2_r, res_r, out_r;
  logic               outv_r;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [63:0]        rdata;
  logic signed [31:0] rh, rt;
  logic [NW-1:0]      nv;
  logic [AW-1:0]      n_last, mid0, nlo, nhi;
  logic               h_le_z;
  logic [34:0]        remsh;
  logic               qbit;
  logic signed [32:0] dt, e;
  logic signed [17:0] rs;

  assign rh     = rdata[63:32];
  assign rt     = rdata[31:0];
  assign nv     = (32'(table_count) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                        : NW'(table_count);
  assign n_last = AW'(nv - NW'(1));
  assign mid0   = n_last >> 1;
  assign h_le_z = 49'(rh) <= w_r.z;
  assign nlo    = h_le_z ? mid_r : lo_r;
  assign nhi    = h_le_z ? hi_r : mid_r;
  assign remsh  = {rem_r[33:0], 1'b0};
  assign qbit   = remsh >= {1'b0, span_r};
  assign dt     = 33'(thi_r) - 33'(tlo_r);
  assign e      = 33'(w_r.temp) - 33'(ref_r);
  assign rs     = {1'b0, w_r.ramp};

  assign q_pop          = (st_r == B_IDLE) && !q_empty;
  assign we             = q_pop && (q_data.op == OP_LOAD)
                          && (32'(q_data.entry_index) < 32'(TABLE_DEPTH));
  assign waddr          = AW'(32'(q_data.entry_index));
  assign out_empty      = !outv_r;
  assign out_source_out = out_r;

  always_comb begin
    case (st_r)
      B_CHK0:  raddr = n_last;
      B_CHKN:  raddr = mid0;
      B_PROBE: raddr = nlo + ((nhi - nlo) >> 1);
      default: raddr = '0;
    endcase
  end

  hstd_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({q_data.entry_height, q_data.entry_temperature}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      outv_r <= 1'b0;
    end else begin
      // a word handed over in B_DONE refills the output register instead
      if (out_pop && outv_r && st_r != B_DONE) begin
        outv_r <= 1'b0;
      end
      case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            w_r <= q_data;
            if (q_data.op == OP_CELL) begin
              if (q_data.ramp == '0 || nv == '0) begin
                res_r <= q_data.src;
                st_r  <= B_DONE;
              end else begin
                st_r <= B_CHK0;
              end
            end
          end
        end
        B_CHK0: begin
          if (w_r.z <= 49'(rh)) begin
            ref_r <= rt;
            st_r  <= B_MUL1;
          end else begin
            hlo_r <= rh;
            tlo_r <= rt;
            lo_r  <= '0;
            st_r  <= B_CHKN;
          end
        end
        B_CHKN: begin
          if (w_r.z >= 49'(rh)) begin
            ref_r <= rt;
            st_r  <= B_MUL1;
          end else begin
            hhi_r <= rh;
            thi_r <= rt;
            hi_r  <= n_last;
            mid_r <= mid0;
            st_r  <= (n_last > AW'(1)) ? B_PROBE : B_DSET;
          end
        end
        B_PROBE: begin
          if (h_le_z) begin
            hlo_r <= rh;
            tlo_r <= rt;
          end else begin
            hhi_r <= rh;
            thi_r <= rt;
          end
          lo_r  <= nlo;
          hi_r  <= nhi;
          mid_r <= nlo + ((nhi - nlo) >> 1);
          if ((nhi - nlo) <= AW'(1)) begin
            st_r <= B_DSET;
          end
        end
        B_DSET: begin
          // h[lo] <= z < h[hi], so both fit once narrowed
          rem_r  <= 35'(w_r.z - 49'(hlo_r));
          span_r <= 34'(33'(hhi_r) - 33'(hlo_r));
          cnt_r  <= '0;
          st_r   <= B_DIV;
        end
        B_DIV: begin
          rem_r <= qbit ? (remsh - {1'b0, span_r}) : remsh;
          q_r   <= {q_r[14:0], qbit};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            st_r <= B_INTERP;
          end
        end
        B_INTERP: begin
          ip_r <= 50'(dt) * 50'($signed({1'b0, q_r}));
          st_r <= B_REF;
        end
        B_REF: begin
          ref_r <= tlo_r + 32'(ip_r >>> 16);
          st_r  <= B_MUL1;
        end
        B_MUL1: begin
          t1_r <= 35'((51'(e) * 51'(rs)) >>> 16);
          st_r <= B_MUL2;
        end
        B_MUL2: begin
          t2_r <= 32'((53'(t1_r) * 53'(rs)) >>> 16);
          st_r <= B_FIN;
        end
        B_FIN: begin
          res_r <= w_r.src - t2_r;
          st_r  <= B_DONE;
        end
        B_DONE: begin
          if (!outv_r || out_pop) begin
            out_r  <= res_r;
            outv_r <= 1'b1;
            st_r   <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // bisection keeps a bracket with positive spacing
  a_span_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_DIV |-> span_r != '0)
    else $error("zero interpolation span");

  a_rem_lt_span: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_DIV |-> {1'b0, rem_r[33:0]} < {1'b0, span_r} && !rem_r[34])
    else $error("divider remainder out of range");

  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_PROBE |-> lo_r < mid_r && mid_r < hi_r)
    else $error("probe outside bracket");

endmodule

### rtl/core/height_sponge_temperature_damping.sv
// ----------------------------------------------------------------------------
// height_sponge_temperature_damping
// Sponge-layer damping of a temperature source term.
// ----------------------------------------------------------------------------
// Input channel (in_push / in_full): a load word (op 0) writes one profile
// entry; a cell word (op 1) yields one damped source value. Loads must come
// in ascending height order; table_count then sets the valid entries.
// Result channel (out_empty / out_pop): one word per cell word, in order.
// Config channel (cfg_valid / cfg_ready): always ready, write only when idle.
// Sequencing: a cell word passes the front states MULZ, ZSUM and MULR; in
// the back it goes straight to the output when no forcing applies, reads the
// table end entries when z falls outside the table, and inside it takes one
// table read per bisection probe and a divider, one quotient bit per cycle,
// for the interpolation weight. The front runs ahead of the back through
// a two-word queue. When the receiver stalls, one result waits in the output
// register, the back then holds, the queue fills and in_full rises.
// Reset restores register defaults and empties all queues; table contents
// are undefined until loaded. No clearing pass is run.
// ----------------------------------------------------------------------------
module height_sponge_temperature_damping import hstd_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_op,
  input  logic        [5:0]  in_entry_index,
  input  logic signed [31:0] in_entry_height,
  input  logic signed [31:0] in_entry_temperature,
  input  logic        [15:0] in_cell_level,
  input  logic signed [31:0] in_cell_temperature,
  input  logic signed [31:0] in_source_in,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_source_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  hstd_cfg_t  cfg_r;
  hstd_work_t fq_wdata, fq_rdata;
  logic       fq_push, fq_full, fq_pop, fq_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.domain_bottom    <= '0;
      cfg_r.cell_height      <= 31'd65536;
      cfg_r.ramp_base        <= '0;
      cfg_r.inv_sponge_depth <= 31'd65536;
      cfg_r.table_count      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DOMAIN_BOTTOM:    cfg_r.domain_bottom    <= cfg_data;
        REG_CELL_HEIGHT:      cfg_r.cell_height      <= cfg_data[30:0];
        REG_RAMP_BASE:        cfg_r.ramp_base        <= cfg_data;
        REG_INV_SPONGE_DEPTH: cfg_r.inv_sponge_depth <= cfg_data[30:0];
        REG_TABLE_COUNT:      cfg_r.table_count      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  hstd_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_op                (in_op),
    .in_entry_index       (in_entry_index),
    .in_entry_height      (in_entry_height),
    .in_entry_temperature (in_entry_temperature),
    .in_cell_level        (in_cell_level),
    .in_cell_temperature  (in_cell_temperature),
    .in_source_in         (in_source_in),
    .cfg                  (cfg_r),
    .q_push               (fq_push),
    .q_data               (fq_wdata),
    .q_full               (fq_full)
  );

  hstd_fifo #(.WIDTH($bits(hstd_work_t))) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  hstd_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (fq_empty),
    .q_pop          (fq_pop),
    .q_data         (fq_rdata),
    .table_count    (cfg_r.table_count),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_source_out (out_source_out)
  );

endmodule
